>>> design/strided_nd_offset_walker_defines.svh
// Assertion helpers shared by the walker RTL.
// Every check is clocked on clk_i and is off while rst_ni is low.
`ifndef STRIDED_ND_OFFSET_WALKER_DEFINES_SVH
`define STRIDED_ND_OFFSET_WALKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNDW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SNDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sndw_pkg.sv
`timescale 1ns / 1ps

package sndw_pkg;

  // Shape of the walk.
  localparam int unsigned RANK        = 4;
  localparam int unsigned EXTENT_BITS = 16;
  localparam int unsigned STRIDE_BITS = 24;
  localparam int unsigned OFFSET_BITS = 42;

  // Derived widths.
  localparam int unsigned PROD_BITS     = EXTENT_BITS + STRIDE_BITS;
  localparam int unsigned NUM_PAIRS     = (RANK + 1) / 2;
  localparam int unsigned CFG_IDX_BITS  = (RANK > 1) ? $clog2(2 * RANK) : 1;
  localparam int unsigned AXIS_BITS     = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int unsigned CFG_DATA_BITS =
      (STRIDE_BITS > EXTENT_BITS) ? STRIDE_BITS : EXTENT_BITS;

  // Register map: extents first, then strides, axis 0 outermost.
  localparam int unsigned CFG_EXTENT_BASE = 0;
  localparam int unsigned CFG_STRIDE_BASE = RANK;

  typedef logic [EXTENT_BITS-1:0] extent_t;
  typedef logic [STRIDE_BITS-1:0] stride_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [PROD_BITS-1:0]   prod_t;

  typedef extent_t [RANK-1:0] extent_vec_t;
  typedef stride_t [RANK-1:0] stride_vec_t;

  // Status of one step, carried alongside the word down the pipeline.
  typedef struct packed {
    logic last;
    logic empty;
  } step_flags_t;

endpackage

>>> design/sndw_axis_counter.sv
`timescale 1ns / 1ps

module sndw_axis_counter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  restart_i,
  input  sndw_pkg::extent_vec_t extent_i,
  output sndw_pkg::extent_vec_t idx_o,
  output sndw_pkg::step_flags_t flags_o
);
  import sndw_pkg::*;

  extent_vec_t idx_q;
  extent_vec_t idx_d;
  extent_vec_t idx_base;
  logic        empty;
  logic        carry;

  // Indices used for this word, and the odometer step with carry toward axis 0.
  always_comb begin
    logic [EXTENT_BITS:0] inc;
    idx_base = restart_i ? '0 : idx_q;
    empty    = 1'b0;
    for (int d = 0; d < RANK; d++) begin
      if (extent_i[d] == '0) begin
        empty = 1'b1;
      end
    end
    idx_d = idx_base;
    carry = 1'b1;
    for (int d = RANK - 1; d >= 0; d--) begin
      inc = {1'b0, idx_base[d]} + {{EXTENT_BITS{1'b0}}, 1'b1};
      if (carry) begin
        if (inc < {1'b0, extent_i[d]}) begin
          idx_d[d] = inc[EXTENT_BITS-1:0];
          carry    = 1'b0;
        end else begin
          idx_d[d] = '0;
        end
      end
    end
    if (empty) begin
      idx_d = '0;
    end
  end

  // Index state moves only when a word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (step_i) begin
      idx_q <= idx_d;
    end
  end

  assign idx_o         = idx_base;
  assign flags_o.empty = empty;
  assign flags_o.last  = empty | carry;

endmodule

>>> design/strided_nd_offset_walker.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; the four
// stages are index step, per-axis multiply, pair add and final add, each
// with its own register and valid bit.
// Reset: indices clear to zero, extents to 1, strides to 0 except the
// innermost stride, which resets to 1; the pipeline empties.
module strided_nd_offset_walker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sndw_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [sndw_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sndw_pkg::OFFSET_BITS-1:0]    offset_o,
  output logic                                last_o,
  output logic                                empty_res_o
);
  import sndw_pkg::*;

  `include "strided_nd_offset_walker_defines.svh"

  extent_vec_t extent_q;
  stride_vec_t stride_q;

  logic        cfg_write;
  logic [CFG_IDX_BITS-1:0] stride_sel;

  logic        in_accept;
  extent_vec_t cnt_idx;
  step_flags_t cnt_flags;

  logic        en1, en2, en3, en4;

  logic        s1_valid_q;
  extent_vec_t s1_idx_q;
  step_flags_t s1_flags_q;

  logic        s2_valid_q;
  prod_t       s2_prod_q [RANK];
  prod_t       s2_prod_d [RANK];
  step_flags_t s2_flags_q;

  logic        s3_valid_q;
  offset_t     s3_pair_q [NUM_PAIRS];
  offset_t     s3_pair_d [NUM_PAIRS];
  step_flags_t s3_flags_q;

  logic        out_valid_q;
  offset_t     offset_q;
  offset_t     offset_d;
  step_flags_t out_flags_q;

  // Configuration registers; the port never stalls.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign stride_sel  = cfg_index_i - CFG_IDX_BITS'(CFG_STRIDE_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < RANK; d++) begin
        extent_q[d] <= extent_t'(1);
        stride_q[d] <= (d == RANK - 1) ? stride_t'(1) : '0;
      end
    end else if (cfg_write) begin
      if (cfg_index_i < CFG_IDX_BITS'(CFG_STRIDE_BASE)) begin
        extent_q[cfg_index_i[AXIS_BITS-1:0]] <= cfg_data_i[EXTENT_BITS-1:0];
      end else if ({1'b0, cfg_index_i} < (CFG_IDX_BITS + 1)'(2 * RANK)) begin
        stride_q[stride_sel[AXIS_BITS-1:0]] <= cfg_data_i[STRIDE_BITS-1:0];
      end
    end
  end

  // Stage enables: a stage loads when it is empty or its successor moves on.
  assign en4        = !out_valid_q || out_ready_i;
  assign en3        = !s3_valid_q || en4;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;
  assign in_accept  = in_valid_i & in_ready_o;

  // Index odometer, stepped once per accepted word.
  sndw_axis_counter u_counter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_accept),
    .restart_i (restart_i),
    .extent_i  (extent_q),
    .idx_o     (cnt_idx),
    .flags_o   (cnt_flags)
  );

  // Per-axis products of index and stride.
  always_comb begin
    for (int d = 0; d < RANK; d++) begin
      s2_prod_d[d] = prod_t'(s1_idx_q[d]) * prod_t'(stride_q[d]);
    end
  end

  // Pairwise sums of the products.
  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      s3_pair_d[p] = OFFSET_BITS'(s2_prod_q[2 * p]);
      if (2 * p + 1 < RANK) begin
        s3_pair_d[p] = s3_pair_d[p] + OFFSET_BITS'(s2_prod_q[2 * p + 1]);
      end
    end
  end

  // Final sum; an empty walk reports offset zero.
  always_comb begin
    offset_d = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      offset_d = offset_d + s3_pair_q[p];
    end
    if (s3_flags_q.empty) begin
      offset_d = '0;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q  <= in_valid_i;
      if (en2) s2_valid_q  <= s1_valid_q;
      if (en3) s3_valid_q  <= s2_valid_q;
      if (en4) out_valid_q <= s3_valid_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_idx_q   <= cnt_idx;
      s1_flags_q <= cnt_flags;
    end
    if (en2 && s1_valid_q) begin
      s2_prod_q  <= s2_prod_d;
      s2_flags_q <= s1_flags_q;
    end
    if (en3 && s2_valid_q) begin
      s3_pair_q  <= s3_pair_d;
      s3_flags_q <= s2_flags_q;
    end
    if (en4 && s3_valid_q) begin
      offset_q    <= offset_d;
      out_flags_q <= s3_flags_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign offset_o    = offset_q;
  assign last_o      = out_flags_q.last;
  assign empty_res_o = out_flags_q.empty;

  // Checks on the walker's own logic.
  `SNDW_ASSERT_SAME(a_empty_is_last_zero, out_valid_o && empty_res_o, last_o && (offset_o == '0), "empty walk word must be last with offset zero")
  `SNDW_ASSERT_SAME(a_stall_only_when_full, !in_ready_o, out_valid_o && !out_ready_i, "input stalled while the output side is free")
  `SNDW_ASSERT_NEXT(a_restart_zeroes, in_accept && restart_i, s1_idx_q == '0, "restart did not zero the indices")

endmodule
